// ===== rtl/wpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Wildcard pattern matcher package
// Shared constants, register indexes and the mode decode carried to the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package wpm_pkg;

    // Largest pattern the registers can hold and the default cell count.
    localparam int REG_BYTES       = 16;
    localparam int PATTERN_MAX_DEF = 16;

    // Register file widths.
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int LEN_REG_W   = 5;
    localparam int MODE_REG_W  = 2;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PAT_LEN  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MODE     = 2'd3;

    // Match mode codes; the unused code behaves as legacy.
    localparam logic [MODE_REG_W-1:0] MODE_EXACT  = 2'd0;
    localparam logic [MODE_REG_W-1:0] MODE_GLOB   = 2'd1;
    localparam logic [MODE_REG_W-1:0] MODE_LEGACY = 2'd2;

    // Wildcard characters.
    localparam logic [7:0] STAR_CHAR  = 8'h2A;
    localparam logic [7:0] QMARK_CHAR = 8'h3F;
    localparam logic [7:0] DOT_CHAR   = 8'h2E;

    // Decoded mode, shared by every cell.
    typedef struct packed {
        logic star_en;    // '*' matches any run
        logic qmark_any;  // '?' matches any single byte
        logic dot_any;    // '.' matches any single byte
    } mode_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/wildcard_pattern_matcher.sv =====
// ----------------------------------------------------------------------------
// Wildcard pattern matcher
// Matches a byte stream against a configured wildcard pattern with a row of
// position cells and gives one match flag per text.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload                                 | Marker
//  s_axis   | in        | tdata[7:0] text_char                    | tlast last_char,
//           |           |                                         | tuser empty_text
//  m_axis   | out       | tdata[0] matched, tdata[7:1] zero       | none
//  cfg      | in        | cfg_wdata by cfg_index, write-only      | none
//
// One item per clock while s_tready is high; a byte is handled in the cycle it is accepted, through
// one combinational pass along the row of position cells.
// A result appears in the output register on the cycle after its item.
// s_tready is low only while a result waits and m_tready is low.
// Synchronous active-low reset clears the cells and the other registers and
// sets the text start flag, so the next byte after reset starts a new text.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_pattern_matcher #(
    parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input items
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [7:0] text_char
    input  wire logic                            s_tlast,   // last_char
    input  wire logic                            s_tuser,   // [0] empty_text
    // Result items
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [7:0]                           m_tdata,   // [0] matched, [7:1] zero
    // Configuration writes
    input  wire logic                            cfg_wr_en,
    input  wire logic [wpm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [wpm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int NumCells = (PATTERN_MAX < wpm_pkg::REG_BYTES) ?
                              PATTERN_MAX : wpm_pkg::REG_BYTES;
    localparam int LenW     = $clog2(NumCells + 1);

    // Configuration registers.
    logic [wpm_pkg::CFG_DATA_W-1:0] pat_low_reg;
    logic [wpm_pkg::CFG_DATA_W-1:0] pat_high_reg;
    logic [wpm_pkg::LEN_REG_W-1:0]  pat_len_reg;
    logic [wpm_pkg::MODE_REG_W-1:0] mode_reg;

    // Control and output registers.
    logic at_start_reg;
    logic at_start_next;
    logic tail_reg;
    logic tail_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic matched_reg;
    logic matched_next;

    logic [2*wpm_pkg::CFG_DATA_W-1:0] pat_all;
    logic [LenW-1:0]                  eff_len;
    logic [NumCells-1:0]              pos_used;
    logic [NumCells-1:0]              pos_keep;
    wpm_pkg::mode_ctl_t               mode_ctl;

    logic accept;
    logic start_sel;
    logic upd;
    logic clr;

    logic [NumCells:0] c_chain;
    logic [NumCells:0] adv_chain;
    logic [NumCells:0] d_chain;
    logic [NumCells:0] c_vec;
    logic [NumCells:0] d_vec;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
            mode_reg     <= wpm_pkg::MODE_EXACT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                wpm_pkg::REG_PAT_LOW:  pat_low_reg  <= cfg_wdata;
                wpm_pkg::REG_PAT_HIGH: pat_high_reg <= cfg_wdata;
                wpm_pkg::REG_PAT_LEN:  pat_len_reg  <= cfg_wdata[wpm_pkg::LEN_REG_W-1:0];
                wpm_pkg::REG_MODE:     mode_reg     <= cfg_wdata[wpm_pkg::MODE_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate the length, build the position masks and decode the mode.
    always_comb begin
        pat_all = {pat_high_reg, pat_low_reg};
        if (32'(pat_len_reg) > 32'(NumCells)) begin
            eff_len = LenW'(NumCells);
        end else begin
            eff_len = LenW'(pat_len_reg);
        end
        for (int i = 0; i < NumCells; i++) begin
            pos_used[i] = (i < int'(eff_len));
            pos_keep[i] = (i <= int'(eff_len));
        end
        mode_ctl.star_en   = (mode_reg != wpm_pkg::MODE_EXACT);
        mode_ctl.qmark_any = (mode_reg == wpm_pkg::MODE_GLOB);
        mode_ctl.dot_any   = (mode_reg != wpm_pkg::MODE_EXACT) &&
                             (mode_reg != wpm_pkg::MODE_GLOB);
    end

    // Handshake and cell control.
    always_comb begin
        s_tready  = !out_valid_reg || m_tready;
        accept    = s_tvalid && s_tready;
        start_sel = at_start_reg || s_tuser;
        upd       = accept && !s_tlast && !s_tuser;
        clr       = accept && (s_tlast || s_tuser);
    end

    assign c_chain[0]   = 1'b0;
    assign adv_chain[0] = 1'b0;
    assign d_chain[0]   = 1'b0;

    // Row of position cells.
    for (genvar g = 0; g < NumCells; g++) begin : g_cell
        wpm_cell #(
            .FIRST (g == 0)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .pat_byte  (pat_all[g*8 +: 8]),
            .pos_used  (pos_used[g]),
            .pos_keep  (pos_keep[g]),
            .mode_ctl  (mode_ctl),
            .text_char (s_tdata),
            .start_sel (start_sel),
            .upd       (upd),
            .clr       (clr),
            .c_in      (c_chain[g]),
            .adv_in    (adv_chain[g]),
            .d_in      (d_chain[g]),
            .c_out     (c_chain[g+1]),
            .adv_out   (adv_chain[g+1]),
            .d_out     (d_chain[g+1]),
            .c_bit     (c_vec[g]),
            .d_bit     (d_vec[g])
        );
    end

    // The final position holds no pattern byte; it collects the row's carries and keeps its tail bit.
    assign c_vec[NumCells] = ((tail_reg && !start_sel) || c_chain[NumCells]) &&
                             (int'(eff_len) == NumCells);
    assign d_vec[NumCells] = adv_chain[NumCells] || d_chain[NumCells];

    always_comb begin
        tail_next = tail_reg;
        if (clr) begin
            tail_next = 1'b0;
        end else if (upd) begin
            tail_next = d_vec[NumCells];
        end
    end

    // Text start flag and result register.
    always_comb begin
        at_start_next  = at_start_reg;
        out_valid_next = out_valid_reg && !m_tready;
        matched_next   = matched_reg;
        if (accept) begin
            at_start_next = clr;
        end
        if (clr) begin
            out_valid_next = 1'b1;
            matched_next   = s_tuser ? c_vec[eff_len] : d_vec[eff_len];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_start_reg  <= 1'b1;
            tail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            matched_reg   <= 1'b0;
        end else begin
            at_start_reg  <= at_start_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
            matched_reg   <= matched_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, matched_reg};

endmodule

`default_nettype wire

// ===== rtl/wpm_cell.sv =====
// ----------------------------------------------------------------------------
// Wildcard pattern matcher cell
// Holds the active bit of one pattern position and passes the closure and
// advance terms to the next position.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_cell #(
    parameter bit FIRST = 1'b0
) (
    input  wire                logic         aclk,
    input  wire                logic         aresetn,
    input  wire                logic [7:0]   pat_byte,
    input  wire                logic         pos_used,    // position < length
    input  wire                logic         pos_keep,    // position <= length
    input  wire wpm_pkg::mode_ctl_t          mode_ctl,
    input  wire                logic [7:0]   text_char,
    input  wire                logic         start_sel,   // load the text start vector
    input  wire                logic         upd,         // keep the next vector
    input  wire                logic         clr,         // text finished
    input  wire                logic         c_in,        // closure carry from the left
    input  wire                logic         adv_in,      // byte consumed by the left cell
    input  wire                logic         d_in,        // next-vector closure carry
    output logic                             c_out,
    output logic                             adv_out,
    output logic                             d_out,
    output logic                             c_bit,       // current vector, closed
    output logic                             d_bit        // next vector, closed
);

    logic active_reg;
    logic active_next;
    logic a_bit;
    logic is_star;
    logic is_any;
    logic hit;

    // Decode the pattern byte under the current mode.
    always_comb begin
        is_star = pos_used && mode_ctl.star_en && (pat_byte == wpm_pkg::STAR_CHAR);
        is_any  = (mode_ctl.qmark_any && (pat_byte == wpm_pkg::QMARK_CHAR)) ||
                  (mode_ctl.dot_any && (pat_byte == wpm_pkg::DOT_CHAR));
        hit     = pos_used && !is_star && (is_any || (pat_byte == text_char));
    end

    // Close the current vector, advance by one byte and close again.
    always_comb begin
        a_bit   = start_sel ? FIRST : active_reg;
        c_bit   = (a_bit || c_in) && pos_keep;
        c_out   = c_bit && is_star;
        adv_out = c_bit && hit;
        d_bit   = adv_in || (c_bit && is_star) || d_in;
        d_out   = d_bit && is_star;
    end

    // Active bit of this position.
    always_comb begin
        active_next = active_reg;
        if (clr) begin
            active_next = 1'b0;
        end else if (upd) begin
            active_next = d_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
        end
    end

endmodule

`default_nettype wire
